[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define MIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Check that a condition never holds outside reset.
`define MIS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define MIS_ASSERT(lbl, prop)
`define MIS_NEVER(lbl, cond)

`endif

`endif

[rtl/mis_pkg.sv]
`timescale 1ns / 1ps
package mis_pkg;

  // Largest matrix dimension the cell row supports
  localparam int MAX_DIM = 8;
  localparam int ROW_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);

  // Divider: 32-bit magnitude shifted up by 16, one quotient bit per cycle
  localparam int DIV_W   = 48;

  // Shared sequencer counter, wide enough for divider and accumulate waits
  localparam int CNT_W   = 7;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b1;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PIV,
    S_DIV,
    S_DIVWR,
    S_ELIM,
    S_INV_RD,
    S_INV_OUT,
    S_SOL_ACC,
    S_SING
  } state_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] ord;
    logic [DIM_W-1:0] n;
    logic             ld_mat;
    logic             ld_rhs;
    logic [ROW_W-1:0] ld_row;
    logic [ROW_W-1:0] ld_col;
    q_t               ld_val;
    logic             div_start;
    logic             div_step;
    logic             div_wr;
    q_t               sel;
    logic             elim_wr;
    logic [ROW_W-1:0] wr_row;
    logic             sol_en;
    logic             sh_load;
    logic             sh_shift;
  } cell_ctrl_t;

  // Saturate a 33-bit sum or difference to the Q16.16 range
  function automatic q_t sat33(input logic signed [32:0] v);
    q_t r;
    if (v > 33'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -33'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a Q32.32 product to Q16.16, ties upward, then saturate
  function automatic q_t q_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [47:0] s;
    q_t r;
    t = p + 64'sd32768;
    s = t[63:16];
    if (s > 48'sd2147483647) begin
      r = Q_MAX;
    end else if (s < -48'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/mis_cell.sv]
`timescale 1ns / 1ps
module mis_cell #(
  parameter int IDX = 0
) (
  input  logic               clk_i,
  input  mis_pkg::cell_ctrl_t ctrl_i,
  input  mis_pkg::q_t        acc_i,
  input  mis_pkg::q_t        sh_i,
  output mis_pkg::q_t        acc_o,
  output mis_pkg::q_t        sh_o,
  output mis_pkg::q_t        rd_data_o
);
  import mis_pkg::*;

  // One column of the working matrix plus this column's right-hand element
  q_t col_q [MAX_DIM];
  q_t rhs_q;
  q_t prow_q;

  // Multiply, round and write-back pipeline
  logic signed [63:0] prod_q;
  q_t p_q, old1_q, old2_q;

  // Chain registers
  q_t acc_q, sh_q;

  // Bit-serial divider
  logic [DIV_W-1:0] dvd_q, quo_q;
  logic [31:0]      rem_q, bmag_q;
  logic             neg_q;

  q_t               rd_data, dvd_src, ma, mb, p_eff, div_res, sub_a;
  logic             mine;
  logic [31:0]      amag, pmag;
  logic [32:0]      trial, diff;
  logic             ge;

  assign rd_data   = col_q[ctrl_i.rd_row];
  assign rd_data_o = rd_data;
  assign mine      = (ctrl_i.ord == ROW_W'(IDX));

  // Divider operands: the pivot column divides one, the others their element
  assign dvd_src = mine ? Q_ONE : rd_data;
  assign amag    = dvd_src[31] ? (~dvd_src + 32'd1) : dvd_src;
  assign pmag    = ctrl_i.sel[31] ? (~ctrl_i.sel + 32'd1) : ctrl_i.sel;
  assign trial   = {rem_q, dvd_q[DIV_W-1]};
  assign diff    = trial - {1'b0, bmag_q};
  assign ge      = (trial >= {1'b0, bmag_q});

  // Apply sign and saturate the quotient
  always_comb begin
    if (neg_q) begin
      if (quo_q > 48'h0000_8000_0000) div_res = Q_MIN;
      else                            div_res = ~quo_q[31:0] + 32'd1;
    end else begin
      if (quo_q > 48'h0000_7fff_ffff) div_res = Q_MAX;
      else                            div_res = quo_q[31:0];
    end
  end

  // Operands: elimination uses pivot row times factor, solve uses row times rhs
  assign ma    = ctrl_i.sol_en ? rd_data : prow_q;
  assign mb    = ctrl_i.sol_en ? rhs_q : ctrl_i.sel;
  assign p_eff = (IDX < int'(ctrl_i.n)) ? p_q : '0;
  assign sub_a = mine ? '0 : old2_q;

  // Run the divider
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dvd_q  <= {amag, 16'h0000};
      rem_q  <= '0;
      quo_q  <= '0;
      bmag_q <= pmag;
      neg_q  <= dvd_src[31] ^ ctrl_i.sel[31];
    end else if (ctrl_i.div_step) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  // Advance the multiply pipeline every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    p_q    <= q_round(prod_q);
    old1_q <= rd_data;
    old2_q <= old1_q;
  end

  // Write the column: load, pivot row scaling, elimination
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_mat && (ctrl_i.ld_col == ROW_W'(IDX))) begin
      col_q[ctrl_i.ld_row] <= ctrl_i.ld_val;
    end
    if (ctrl_i.ld_rhs && (ctrl_i.ld_col == ROW_W'(IDX))) begin
      rhs_q <= ctrl_i.ld_val;
    end
    if (ctrl_i.div_wr) begin
      col_q[ctrl_i.ord] <= div_res;
      prow_q            <= div_res;
    end
    if (ctrl_i.elim_wr) begin
      col_q[ctrl_i.wr_row] <= sat33({sub_a[31], sub_a} - {p_q[31], p_q});
    end
  end

  // Pass the running sum right and the readout row left
  always_ff @(posedge clk_i) begin
    acc_q <= sat33({acc_i[31], acc_i} + {p_eff[31], p_eff});
    if (ctrl_i.sh_load) begin
      sh_q <= rd_data;
    end else if (ctrl_i.sh_shift) begin
      sh_q <= sh_i;
    end
  end

  assign acc_o = acc_q;
  assign sh_o  = sh_q;

endmodule

[rtl/mis_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mis_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mis_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mis_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mis_pkg::q_t                     in_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mis_pkg::q_t                     out_value_o,
  output logic                            singular_o,
  output logic [2:0]                      failing_row_o,
  output logic                            last_o,
  input  mis_pkg::q_t                     rd_data_i [mis_pkg::MAX_DIM],
  input  mis_pkg::q_t                     acc_last_i,
  input  mis_pkg::q_t                     sh_first_i,
  output mis_pkg::cell_ctrl_t             ctrl_o
);
  import mis_pkg::*;

  state_e state_q, state_d;
  logic [CFG_W-1:0] size_q;
  logic             mode_q;
  logic [ROW_W-1:0] ord_q, ord_d, row_q, row_d, lr_q, lr_d, lc_q, lc_d;
  logic             rhs_ph_q, rhs_ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m2;

  logic             out_valid_q;
  q_t               out_value_q;
  logic             out_sing_q, out_last_q;
  logic [2:0]       out_row_q;

  logic             emit, emit_sing, emit_last, out_free, in_acc;
  q_t               emit_val;
  logic [DIM_W-1:0] n_use;
  logic [ROW_W-1:0] nm1;
  q_t               sel_data;

  // Clamp the dimension into the supported range
  always_comb begin
    if (size_q == '0) begin
      n_use = DIM_W'(1);
    end else if (int'(size_q) > MAX_DIM) begin
      n_use = DIM_W'(MAX_DIM);
    end else begin
      n_use = DIM_W'(size_q);
    end
  end
  assign nm1 = ROW_W'(n_use - DIM_W'(1));

  assign sel_data   = rd_data_i[ord_q];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_m2     = cnt_q - CNT_W'(2);

  // Sequence load, elimination and readout
  always_comb begin
    state_d   = state_q;
    ord_d     = ord_q;
    row_d     = row_q;
    lr_d      = lr_q;
    lc_d      = lc_q;
    rhs_ph_d  = rhs_ph_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    emit_val  = '0;
    emit_sing = 1'b0;
    emit_last = 1'b0;
    ctrl_o           = '0;
    ctrl_o.n         = n_use;
    ctrl_o.ord       = ord_q;
    ctrl_o.ld_row    = lr_q;
    ctrl_o.ld_col    = lc_q;
    ctrl_o.ld_val    = in_value_i;
    ctrl_o.sel       = sel_data;
    ctrl_o.rd_row    = ord_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          ctrl_o.ld_mat = !rhs_ph_q;
          ctrl_o.ld_rhs = rhs_ph_q;
          if (lc_q == nm1) begin
            lc_d = '0;
            if (rhs_ph_q || (lr_q == nm1 && !mode_q)) begin
              lr_d     = '0;
              rhs_ph_d = 1'b0;
              ord_d    = '0;
              state_d  = S_PIV;
            end else if (lr_q == nm1) begin
              rhs_ph_d = 1'b1;
            end else begin
              lr_d = lr_q + ROW_W'(1);
            end
          end else begin
            lc_d = lc_q + ROW_W'(1);
          end
        end
      end
      S_PIV: begin
        if (sel_data == '0) begin
          state_d = S_SING;
        end else begin
          ctrl_o.div_start = 1'b1;
          cnt_d            = '0;
          state_d          = S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          state_d = S_DIVWR;
        end
      end
      S_DIVWR: begin
        ctrl_o.div_wr = 1'b1;
        cnt_d         = '0;
        state_d       = S_ELIM;
      end
      S_ELIM: begin
        ctrl_o.rd_row = cnt_q[ROW_W-1:0];
        ctrl_o.wr_row = cnt_m2[ROW_W-1:0];
        ctrl_o.elim_wr = (cnt_q >= CNT_W'(2)) && (cnt_m2[ROW_W-1:0] != ord_q);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(n_use) + CNT_W'(1)) begin
          cnt_d = '0;
          if (ord_q == nm1) begin
            row_d   = '0;
            state_d = mode_q ? S_SOL_ACC : S_INV_RD;
          end else begin
            ord_d   = ord_q + ROW_W'(1);
            state_d = S_PIV;
          end
        end
      end
      S_INV_RD: begin
        ctrl_o.rd_row  = row_q;
        ctrl_o.sh_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_INV_OUT;
      end
      S_INV_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_val        = sh_first_i;
          emit_last       = (row_q == nm1) && (cnt_q[ROW_W-1:0] == nm1);
          ctrl_o.sh_shift = 1'b1;
          cnt_d           = cnt_q + CNT_W'(1);
          if (cnt_q[ROW_W-1:0] == nm1) begin
            cnt_d = '0;
            if (row_q == nm1) begin
              state_d = S_LOAD;
            end else begin
              row_d   = row_q + ROW_W'(1);
              state_d = S_INV_RD;
            end
          end
        end
      end
      S_SOL_ACC: begin
        ctrl_o.rd_row = row_q;
        ctrl_o.sol_en = 1'b1;
        if (cnt_q == CNT_W'(MAX_DIM + 2)) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_val  = acc_last_i;
            emit_last = (row_q == nm1);
            cnt_d     = '0;
            if (row_q == nm1) begin
              state_d = S_LOAD;
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SING: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_sing = 1'b1;
          emit_last = 1'b1;
          state_d   = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase

    // A register write restarts loading
    if (cfg_we_i) begin
      lr_d     = '0;
      lc_d     = '0;
      rhs_ph_d = 1'b0;
    end
  end

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      ord_q    <= '0;
      row_q    <= '0;
      lr_q     <= '0;
      lc_q     <= '0;
      rhs_ph_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ord_q    <= ord_d;
      row_q    <= row_d;
      lr_q     <= lr_d;
      lc_q     <= lc_d;
      rhs_ph_q <= rhs_ph_d;
      cnt_q    <= cnt_d;
    end
  end

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CFG_W'(8);
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE: size_q <= cfg_data_i;
        REG_MODE: mode_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= emit_val;
      out_sing_q  <= emit_sing;
      out_row_q   <= emit_sing ? 3'(ord_q) : 3'b000;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign singular_o    = out_sing_q;
  assign failing_row_o = out_row_q;
  assign last_o        = out_last_q;

  `MIS_ASSERT(a_sing_last, (out_valid_q && out_sing_q) |-> out_last_q)
  `MIS_NEVER(a_no_pivot_row_wr, ctrl_o.elim_wr && (ctrl_o.wr_row == ord_q))
  `MIS_ASSERT(a_ord_in_range, (state_q != S_LOAD) |-> (ord_q <= nm1))
  `MIS_ASSERT(a_div_len, (state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_W)))
  `MIS_ASSERT(a_emit_free, emit |-> out_free)

endmodule

[rtl/matrix_inverse_solver.sv]
`timescale 1ns / 1ps
// Gauss-Jordan inverter for an N x N signed Q16.16 matrix (N up to 8), no row
// exchange, saturating arithmetic. Load the matrix row-major, one item per
// cycle, then in solve mode N right-hand items. The block then eliminates: per
// pivot a read, a division in the bit-serial dividers (one per column cell,
// all running together), a write and a pipelined multiply-subtract across the
// cells. It emits the inverse row-major, one item per cycle within a row while
// the output is not stalled, or in solve mode one solution item per row once
// the running sum has walked the cell chain. A zero pivot ends the run with a
// single flagged item. Write the registers only while idle; a write restarts
// loading.
`include "assert_macros.svh"
module matrix_inverse_solver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mis_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            out_value_o,
  output logic                          singular_o,
  output logic [2:0]                    failing_row_o,
  output logic                          last_o
);
  import mis_pkg::*;

  cell_ctrl_t ctrl;
  q_t         rd_data [MAX_DIM];
  q_t         acc_o   [MAX_DIM];
  q_t         sh_o    [MAX_DIM];

  // Row of column cells
  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    q_t acc_in, sh_in;
    if (k == 0) begin : g_first
      assign acc_in = '0;
    end else begin : g_mid
      assign acc_in = acc_o[k-1];
    end
    if (k == MAX_DIM - 1) begin : g_end
      assign sh_in = '0;
    end else begin : g_inner
      assign sh_in = sh_o[k+1];
    end
    mis_cell #(.IDX(k)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .acc_i     (acc_in),
      .sh_i      (sh_in),
      .acc_o     (acc_o[k]),
      .sh_o      (sh_o[k]),
      .rd_data_o (rd_data[k])
    );
  end

  mis_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_value_i    (in_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_value_o   (out_value_o),
    .singular_o    (singular_o),
    .failing_row_o (failing_row_o),
    .last_o        (last_o),
    .rd_data_i     (rd_data),
    .acc_last_i    (acc_o[MAX_DIM-1]),
    .sh_first_i    (sh_o[0]),
    .ctrl_o        (ctrl)
  );

  `MIS_ASSERT(a_no_load_busy, (ctrl.ld_mat || ctrl.ld_rhs) |-> !in_stall_o)
  `MIS_NEVER(a_one_writer, ctrl.div_wr && (ctrl.elim_wr || ctrl.ld_mat))
  `MIS_ASSERT(a_fail_zero, (out_valid_o && !singular_o) |-> (failing_row_o == 3'b000))

endmodule
